@@ rtl/tmh_pkg.sv @@
// shared types, constants and codes for the timer min-heap
package tmh_pkg;

    localparam int CAPACITY    = 64;
    localparam int TIME_BITS   = 48;
    localparam int TAG_BITS    = 16;
    localparam int HANDLE_BITS = 6;
    localparam int CNT_BITS    = 7;
    localparam int GROUPS      = (CAPACITY + 7) / 8;
    localparam int GRP_BITS    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0]             mode;
        logic [TIME_BITS-1:0]   deadline_ms;
        logic [TIME_BITS-1:0]   now_ms;
        logic [TAG_BITS-1:0]    payload_tag;
        logic [HANDLE_BITS-1:0] cancel_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] handle;
        logic [TAG_BITS-1:0]    payload_out;
        logic [TIME_BITS-1:0]   delay_ms;
        logic                   last;
    } rsp_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   dl;
        logic [HANDLE_BITS-1:0] h;
    } heap_ent_t;

    typedef enum logic [1:0] {
        RA_ZERO    = 2'd0,
        RA_PARENT  = 2'd1,
        RA_LEFT    = 2'd2,
        RA_LASTPOS = 2'd3
    } ra_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    scan_step;
        logic    ins_start;
        logic    full_res;
        logic    can_bad;
        logic    can_take;
        logic    load_last;
        logic    dn_step;
        logic    up_step;
        logic    place_held;
        logic    emit;
        logic    exp_take;
        logic    exp_end;
        logic    q_data;
        logic    set_tag;
        logic    pay_head;
        ra_sel_t ra_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       cnt_full;
        logic       cnt_zero;
        logic       scan_hit;
        logic       in_use_ch;
        logic       pos_is_last;
        logic       dn_move;
        logic       cur_zero;
        logic       up_move;
        logic       exp_fire;
        logic       pend;
        logic       out_free;
    } sts_t;

endpackage

@@ rtl/tmh_ctrl.sv @@
// control state machine for the timer min-heap
module tmh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    req_mode,
    output logic          idle,
    input  tmh_pkg::sts_t sts,
    output tmh_pkg::cmd_t cmd
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_I_CHK  = 17'h00002,
        S_I_SCAN = 17'h00004,
        S_C_CHK  = 17'h00008,
        S_C_DATA = 17'h00010,
        S_C_LAST = 17'h00020,
        S_DN_RD  = 17'h00040,
        S_DN_CMP = 17'h00080,
        S_UP_RD  = 17'h00100,
        S_UP_CMP = 17'h00200,
        S_DONE   = 17'h00400,
        S_E_RD   = 17'h00800,
        S_E_CMP  = 17'h01000,
        S_E_LAST = 17'h02000,
        S_Q_RD   = 17'h04000,
        S_Q_DATA = 17'h08000,
        S_Q_TAG  = 17'h10000
    } state_t;

    state_t state_reg, state_next, fin_state;

    assign idle      = (state_reg == S_IDLE);
    assign fin_state = (sts.mode == tmh_pkg::MODE_EXPIRE) ? S_E_RD : S_DONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ra_sel = tmh_pkg::RA_ZERO;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (req_mode)
                        tmh_pkg::MODE_INSERT: state_next = S_I_CHK;
                        tmh_pkg::MODE_CANCEL: state_next = S_C_CHK;
                        tmh_pkg::MODE_EXPIRE: state_next = S_E_RD;
                        default:              state_next = S_Q_RD;
                    endcase
                end
            end
            S_I_CHK:
            begin
                if (sts.cnt_full)
                begin
                    cmd.full_res = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_I_SCAN;
                end
            end
            S_I_SCAN:
            begin
                if (sts.scan_hit)
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = S_UP_RD;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_C_CHK:
            begin
                if (!sts.in_use_ch)
                begin
                    cmd.can_bad = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_C_DATA;
                end
            end
            S_C_DATA:
            begin
                cmd.can_take = 1'b1;
                cmd.ra_sel   = tmh_pkg::RA_LASTPOS;
                state_next   = sts.pos_is_last ? S_DONE : S_C_LAST;
            end
            S_C_LAST:
            begin
                cmd.load_last = 1'b1;
                state_next    = S_DN_RD;
            end
            S_DN_RD:
            begin
                cmd.ra_sel = tmh_pkg::RA_LEFT;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (sts.dn_move)
                begin
                    cmd.dn_step = 1'b1;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                cmd.ra_sel = tmh_pkg::RA_PARENT;
                if (sts.cur_zero)
                begin
                    cmd.place_held = 1'b1;
                    state_next     = fin_state;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_move)
                begin
                    cmd.up_step = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.place_held = 1'b1;
                    state_next     = fin_state;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_E_RD:
            begin
                state_next = S_E_CMP;
            end
            S_E_CMP:
            begin
                if (sts.exp_fire)
                begin
                    // a held earlier fire must leave before the next one replaces it
                    if (!sts.pend || sts.out_free)
                    begin
                        cmd.emit     = sts.pend;
                        cmd.exp_take = 1'b1;
                        cmd.ra_sel   = tmh_pkg::RA_LASTPOS;
                        cmd.pay_head = 1'b1;
                        state_next   = S_E_LAST;
                    end
                end
                else if (sts.out_free)
                begin
                    cmd.exp_end = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_E_LAST:
            begin
                cmd.set_tag = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = S_E_RD;
                end
                else
                begin
                    cmd.load_last = 1'b1;
                    state_next    = S_DN_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_DATA;
            end
            S_Q_DATA:
            begin
                cmd.q_data   = 1'b1;
                cmd.pay_head = 1'b1;
                state_next   = S_Q_TAG;
            end
            S_Q_TAG:
            begin
                cmd.set_tag = !sts.cnt_zero;
                state_next  = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tmh_dp.sv @@
// heap memories, handle table, sift datapath and result register
module tmh_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  tmh_pkg::req_t req,
    input  tmh_pkg::cmd_t cmd,
    output tmh_pkg::sts_t sts,
    input  logic          rsp_stall,
    output logic          rsp_valid,
    output tmh_pkg::rsp_t rsp
);

    localparam int HB = tmh_pkg::HANDLE_BITS;
    localparam int CB = tmh_pkg::CNT_BITS;
    localparam int TB = tmh_pkg::TIME_BITS;

    tmh_pkg::heap_ent_t heap_mem [tmh_pkg::CAPACITY];
    logic [HB-1:0]                pos_mem [tmh_pkg::CAPACITY];
    logic [tmh_pkg::TAG_BITS-1:0] pay_mem [tmh_pkg::CAPACITY];

    tmh_pkg::heap_ent_t           ra_reg, rb_reg;
    logic [HB-1:0]                pos_reg;
    logic [tmh_pkg::TAG_BITS-1:0] pay_reg;

    tmh_pkg::req_t                item_reg;
    logic [tmh_pkg::CAPACITY-1:0] in_use_reg;
    logic [CB-1:0]                cnt_reg;
    logic [HB-1:0]                cur_reg;
    logic [TB-1:0]                key_reg;
    logic [HB-1:0]                kh_reg;
    logic [tmh_pkg::GRP_BITS-1:0] grp_reg;
    logic                         pend_reg;
    tmh_pkg::rsp_t                stage_reg;
    logic                         out_valid_reg;
    tmh_pkg::rsp_t                out_reg;

    logic [HB-1:0]  ra_addr, rb_addr, pay_addr, par, new_h, m_idx;
    logic [CB:0]    l_idx, r_idx;
    logic [CB-1:0]  cnt_m1;
    logic           take_l, take_r, wr_en, out_free;
    logic [TB-1:0]  m_key, delay;
    tmh_pkg::heap_ent_t wr_ent, child;
    logic [tmh_pkg::GROUPS*8-1:0] used_pad;
    logic [7:0]     free_grp;
    logic [2:0]     enc;
    logic [tmh_pkg::GRP_BITS+2:0] h_wide;

    assign cnt_m1 = cnt_reg - CB'(1);
    assign par    = HB'((cur_reg - HB'(1)) >> 1);
    assign l_idx  = (CB+1)'({cur_reg, 1'b1});
    assign r_idx  = (CB+1)'({cur_reg, 1'b0}) + (CB+1)'(2);

    always_comb
    begin
        case (cmd.ra_sel)
            tmh_pkg::RA_ZERO:    ra_addr = '0;
            tmh_pkg::RA_PARENT:  ra_addr = par;
            tmh_pkg::RA_LEFT:    ra_addr = l_idx[HB-1:0];
            tmh_pkg::RA_LASTPOS: ra_addr = cnt_m1[HB-1:0];
            default:             ra_addr = '0;
        endcase
    end
    assign rb_addr  = r_idx[HB-1:0];
    assign pay_addr = cmd.pay_head ? ra_reg.h : item_reg.cancel_handle;

    // lowest free handle, eight handles per scan step
    assign used_pad = {{(tmh_pkg::GROUPS*8-tmh_pkg::CAPACITY){1'b1}}, in_use_reg};
    assign free_grp = ~used_pad[grp_reg*8 +: 8];
    always_comb
    begin
        enc = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (free_grp[i])
            begin
                enc = 3'(i);
            end
        end
    end
    assign h_wide = {grp_reg, enc};
    assign new_h  = HB'(h_wide);

    // sift-down pick: strict less-than, left child wins a tie
    assign take_l = (l_idx < (CB+1)'(cnt_reg)) && (ra_reg.dl < key_reg);
    assign m_key  = take_l ? ra_reg.dl : key_reg;
    assign take_r = (r_idx < (CB+1)'(cnt_reg)) && (rb_reg.dl < m_key);
    assign child  = take_r ? rb_reg : ra_reg;
    assign m_idx  = take_r ? r_idx[HB-1:0] : l_idx[HB-1:0];

    assign delay = (item_reg.now_ms >= ra_reg.dl) ? '0 : (ra_reg.dl - item_reg.now_ms);

    always_comb
    begin
        wr_en  = cmd.dn_step | cmd.up_step | cmd.place_held;
        wr_ent = '{dl: key_reg, h: kh_reg};
        if (cmd.dn_step)
        begin
            wr_ent = child;
        end
        else if (cmd.up_step)
        begin
            wr_ent = ra_reg;
        end
    end

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        sts.mode        = item_reg.mode;
        sts.cnt_full    = (cnt_reg >= CB'(tmh_pkg::CAPACITY));
        sts.cnt_zero    = (cnt_reg == '0);
        sts.scan_hit    = |free_grp;
        sts.in_use_ch   = ((HB+1)'(item_reg.cancel_handle) < (HB+1)'(tmh_pkg::CAPACITY))
                          && in_use_reg[item_reg.cancel_handle];
        sts.pos_is_last = (CB'(pos_reg) == cnt_m1);
        sts.dn_move     = take_l || take_r;
        sts.cur_zero    = (cur_reg == '0);
        sts.up_move     = (key_reg < ra_reg.dl);
        sts.exp_fire    = (cnt_reg != '0) && (ra_reg.dl <= item_reg.now_ms);
        sts.pend        = pend_reg;
        sts.out_free    = out_free;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[cur_reg]  <= wr_ent;
            pos_mem[wr_ent.h]  <= cur_reg;
        end
        if (cmd.ins_start)
        begin
            pay_mem[new_h] <= item_reg.payload_tag;
        end
        ra_reg  <= heap_mem[ra_addr];
        rb_reg  <= heap_mem[rb_addr];
        pos_reg <= pos_mem[item_reg.cancel_handle];
        pay_reg <= pay_mem[pay_addr];
    end

    // request, sift key, staged result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.ins_start)
        begin
            key_reg   <= item_reg.deadline_ms;
            kh_reg    <= new_h;
            stage_reg <= '{tmh_pkg::ST_OK, new_h, item_reg.payload_tag, '0, 1'b1};
        end
        if (cmd.load_last)
        begin
            key_reg <= ra_reg.dl;
            kh_reg  <= ra_reg.h;
        end
        if (cmd.full_res)
        begin
            stage_reg <= '{tmh_pkg::ST_FULL, '0, '0, '0, 1'b1};
        end
        if (cmd.can_bad)
        begin
            stage_reg <= '{tmh_pkg::ST_BAD, item_reg.cancel_handle, '0, '0, 1'b1};
        end
        if (cmd.can_take)
        begin
            stage_reg <= '{tmh_pkg::ST_OK, item_reg.cancel_handle, pay_reg, '0, 1'b1};
        end
        if (cmd.exp_take)
        begin
            stage_reg <= '{tmh_pkg::ST_OK, ra_reg.h, '0, '0, 1'b0};
        end
        if (cmd.q_data)
        begin
            if (cnt_reg == '0)
            begin
                stage_reg <= '{tmh_pkg::ST_OK, '0, '0, '1, 1'b1};
            end
            else
            begin
                stage_reg <= '{tmh_pkg::ST_OK, ra_reg.h, '0, delay, 1'b1};
            end
        end
        if (cmd.set_tag)
        begin
            stage_reg.payload_out <= pay_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= stage_reg;
        end
        if (cmd.exp_end)
        begin
            if (pend_reg)
            begin
                out_reg <= '{stage_reg.status, stage_reg.handle, stage_reg.payload_out,
                             stage_reg.delay_ms, 1'b1};
            end
            else
            begin
                out_reg <= '{tmh_pkg::ST_NONE, '0, '0, '0, 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            grp_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                grp_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                grp_reg <= grp_reg + tmh_pkg::GRP_BITS'(1);
            end
            if (cmd.ins_start)
            begin
                in_use_reg[new_h] <= 1'b1;
                cur_reg           <= cnt_reg[HB-1:0];
                cnt_reg           <= cnt_reg + CB'(1);
            end
            if (cmd.can_take)
            begin
                in_use_reg[item_reg.cancel_handle] <= 1'b0;
                cur_reg <= pos_reg;
                cnt_reg <= cnt_m1;
            end
            if (cmd.exp_take)
            begin
                in_use_reg[ra_reg.h] <= 1'b0;
                cur_reg  <= '0;
                cnt_reg  <= cnt_m1;
                pend_reg <= 1'b1;
            end
            if (cmd.exp_end)
            begin
                pend_reg <= 1'b0;
            end
            if (cmd.dn_step)
            begin
                cur_reg <= m_idx;
            end
            if (cmd.up_step)
            begin
                cur_reg <= par;
            end
            if (cmd.emit || cmd.exp_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ rtl/timer_min_heap.sv @@
// top level of the timer min-heap queue
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | tmh_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall  | tmh_pkg::rsp_t
//
// one transaction at a time; req_stall is high from accept until its last result is queued
// query reads the head; insert reports a full heap, else scans handles, then sifts up
// cancel rejects a handle not in use; a non-last entry is refilled by a sift down, then up
// expire checks the head, takes each fired timer and refills by a sift down from the top
// reset clears the in-use bits and the entry count; no clearing pass is needed
// results wait in one output register; a stalled rsp holds the sequencer at its next emit
module timer_min_heap (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tmh_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tmh_pkg::rsp_t rsp
);

    tmh_pkg::cmd_t cmd;
    tmh_pkg::sts_t sts;
    logic          idle;

    assign req_stall = !idle;

    tmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .idle      (idle),
        .sts       (sts),
        .cmd       (cmd)
    );

    tmh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

@@ tb/sv/tb_timer_min_heap.sv @@
`timescale 1ns / 1ps
// testbench for the timer min-heap: directed and random insert, cancel, expire and query
module tb_timer_min_heap;

    // expected-result store with its own heap model
    class timer_scoreboard;
        logic [tmh_pkg::TIME_BITS-1:0]   dl_at [tmh_pkg::CAPACITY];
        logic [tmh_pkg::HANDLE_BITS-1:0] h_at [tmh_pkg::CAPACITY];
        logic [tmh_pkg::HANDLE_BITS-1:0] pos_of [tmh_pkg::CAPACITY];
        logic [tmh_pkg::TAG_BITS-1:0]    tag_of [tmh_pkg::CAPACITY];
        bit                              busy [tmh_pkg::CAPACITY];
        int                              count;
        tmh_pkg::rsp_t                   pending [$];
        int                              errors;
        int                              checked;

        function void clear();
            for (int i = 0; i < tmh_pkg::CAPACITY; i++)
                busy[i] = 0;
            count = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void place(int p, logic [tmh_pkg::TIME_BITS-1:0] d,
                            logic [tmh_pkg::HANDLE_BITS-1:0] h);
            dl_at[p] = d;
            h_at[p] = h;
            pos_of[h] = p[tmh_pkg::HANDLE_BITS-1:0];
        endfunction

        function void swap_pos(int a, int b);
            logic [tmh_pkg::TIME_BITS-1:0]   d;
            logic [tmh_pkg::HANDLE_BITS-1:0] h;
            d = dl_at[a];
            h = h_at[a];
            place(a, dl_at[b], h_at[b]);
            place(b, d, h);
        endfunction

        function void rise(int c);
            int p;
            while (c > 0) begin
                p = (c - 1) / 2;
                if (!(dl_at[c] < dl_at[p]))
                    break;
                swap_pos(c, p);
                c = p;
            end
        endfunction

        function int sink(int c);
            int l;
            int r;
            int m;
            forever begin
                l = 2 * c + 1;
                r = 2 * c + 2;
                m = c;
                if (l < count && dl_at[l] < dl_at[m])
                    m = l;
                if (r < count && dl_at[r] < dl_at[m])
                    m = r;
                if (m == c)
                    return c;
                swap_pos(c, m);
                c = m;
            end
        endfunction

        function void take_out(int p);
            int lp;
            lp = count - 1;
            busy[h_at[p]] = 0;
            if (p != lp)
                place(p, dl_at[lp], h_at[lp]);
            count = lp;
            if (p < count)
                rise(sink(p));
        endfunction

        function void push(logic [1:0] st, logic [tmh_pkg::HANDLE_BITS-1:0] h,
                           logic [tmh_pkg::TAG_BITS-1:0] t,
                           logic [tmh_pkg::TIME_BITS-1:0] d, logic lst);
            tmh_pkg::rsp_t r;
            r.status = st;
            r.handle = h;
            r.payload_out = t;
            r.delay_ms = d;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_request(tmh_pkg::req_t q);
            int h;
            int n;
            logic [tmh_pkg::HANDLE_BITS-1:0] fh;
            case (q.mode)
                tmh_pkg::MODE_INSERT: begin
                    h = 0;
                    while (h < tmh_pkg::CAPACITY && busy[h])
                        h++;
                    if (count >= tmh_pkg::CAPACITY || h >= tmh_pkg::CAPACITY)
                        push(tmh_pkg::ST_FULL, '0, '0, '0, 1'b1);
                    else begin
                        busy[h] = 1;
                        tag_of[h] = q.payload_tag;
                        place(count, q.deadline_ms, h[tmh_pkg::HANDLE_BITS-1:0]);
                        count++;
                        rise(count - 1);
                        push(tmh_pkg::ST_OK, h[tmh_pkg::HANDLE_BITS-1:0], q.payload_tag,
                             '0, 1'b1);
                    end
                end
                tmh_pkg::MODE_CANCEL: begin
                    if (!busy[q.cancel_handle])
                        push(tmh_pkg::ST_BAD, q.cancel_handle, '0, '0, 1'b1);
                    else begin
                        take_out(pos_of[q.cancel_handle]);
                        push(tmh_pkg::ST_OK, q.cancel_handle, tag_of[q.cancel_handle],
                             '0, 1'b1);
                    end
                end
                tmh_pkg::MODE_EXPIRE: begin
                    n = 0;
                    while (count > 0 && dl_at[0] <= q.now_ms) begin
                        fh = h_at[0];
                        take_out(0);
                        push(tmh_pkg::ST_OK, fh, tag_of[fh], '0, 1'b0);
                        n++;
                    end
                    if (n == 0)
                        push(tmh_pkg::ST_NONE, '0, '0, '0, 1'b1);
                    else
                        pending[$].last = 1'b1;
                end
                default: begin
                    if (count == 0)
                        push(tmh_pkg::ST_OK, '0, '0, '1, 1'b1);
                    else
                        push(tmh_pkg::ST_OK, h_at[0], tag_of[h_at[0]],
                             (q.now_ms >= dl_at[0]) ? '0 : dl_at[0] - q.now_ms, 1'b1);
                end
            endcase
        endfunction

        function void check_result(tmh_pkg::rsp_t got);
            tmh_pkg::rsp_t want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            end
            if (got.handle !== want.handle) begin
                errors++;
                $display("%0t: handle exp %0d got %0d", $time, want.handle, got.handle);
            end
            if (got.payload_out !== want.payload_out) begin
                errors++;
                $display("%0t: payload exp %h got %h", $time, want.payload_out,
                         got.payload_out);
            end
            if (got.delay_ms !== want.delay_ms) begin
                errors++;
                $display("%0t: delay exp %h got %h", $time, want.delay_ms, got.delay_ms);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    tmh_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_stall;
    tmh_pkg::rsp_t  rsp;

    timer_scoreboard sb;
    int  idle_cycles;
    int  sent;
    bit  hold_off;
    logic [tmh_pkg::TIME_BITS-1:0] clock_ms;

    timer_min_heap dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // one transaction, with a random gap first
    task automatic send(logic [1:0] m, logic [47:0] d, logic [47:0] n,
                        logic [15:0] t, logic [5:0] h);
        tmh_pkg::req_t q;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req_valid <= 1'b0;
            req <= '0;
            repeat (gap) @(posedge clk);
        end
        q.mode = m;
        q.deadline_ms = d;
        q.now_ms = n;
        q.payload_tag = t;
        q.cancel_handle = h;
        req_valid <= 1'b1;
        req <= q;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(q);
        sent++;
    endtask

    task automatic rand_item();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4)
            send(tmh_pkg::MODE_INSERT, clock_ms + $urandom_range(0, 400), rand48(),
                 16'($urandom()), 6'($urandom()));
        else if (k < 6)
            send(tmh_pkg::MODE_CANCEL, rand48(), rand48(), 16'($urandom()),
                 6'($urandom()));
        else if (k < 8) begin
            clock_ms = clock_ms + $urandom_range(0, 150);
            send(tmh_pkg::MODE_EXPIRE, rand48(), clock_ms, 16'($urandom()),
                 6'($urandom()));
        end else
            send(tmh_pkg::MODE_QUERY, rand48(),
                 $urandom_range(0, 1) ? clock_ms : rand48(), 16'($urandom()),
                 6'($urandom()));
    endtask

    // receiver: random stall per result, one long hold-off on request
    initial
    begin
        int w;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                rsp_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
            if (w > 0) begin
                rsp_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid && !hold_off)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 4000) begin
            $display("timeout at %0t", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int n;
        sb = new();
        sb.clear();
        idle_cycles = 0;
        sent = 0;
        hold_off = 0;
        clock_ms = 1000;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, full heap, ties, cancel
        send(tmh_pkg::MODE_QUERY, '0, '0, '0, '0);
        send(tmh_pkg::MODE_EXPIRE, '1, '1, '1, '1);
        send(tmh_pkg::MODE_CANCEL, '0, '0, '0, 6'd63);
        send(tmh_pkg::MODE_INSERT, '1, '0, 16'hFFFF, '0);
        send(tmh_pkg::MODE_INSERT, '0, '1, 16'h0000, '1);
        send(tmh_pkg::MODE_INSERT, 48'd500, '0, 16'hA5A5, '0);
        send(tmh_pkg::MODE_INSERT, 48'd500, '0, 16'h5A5A, '0);
        send(tmh_pkg::MODE_QUERY, '0, '1, '0, '0);
        send(tmh_pkg::MODE_QUERY, '0, 48'd100, '0, '0);
        send(tmh_pkg::MODE_CANCEL, '0, '0, '0, 6'd2);
        send(tmh_pkg::MODE_CANCEL, '0, '0, '0, 6'd2);
        send(tmh_pkg::MODE_EXPIRE, '0, 48'd500, '0, '0);
        send(tmh_pkg::MODE_EXPIRE, '0, '1, '0, '0);
        send(tmh_pkg::MODE_QUERY, '0, '0, '0, '0);
        // fill to capacity while the receiver holds off, then overflow
        hold_off = 1;
        for (int i = 0; i < tmh_pkg::CAPACITY + 2; i++)
            send(tmh_pkg::MODE_INSERT, rand48() & 48'hFFFF, '0, 16'($urandom()), '0);
        send(tmh_pkg::MODE_CANCEL, '0, '0, '0, 6'd37);
        send(tmh_pkg::MODE_INSERT, 48'h10, '0, 16'h1234, '0);
        send(tmh_pkg::MODE_EXPIRE, '0, '1, '0, '0);

        // random: bounded heap growth with realistic time steps
        n = 0;
        while (n < 36) begin
            rand_item();
            n++;
        end
        send(tmh_pkg::MODE_EXPIRE, '0, '1, '0, '0);
        req_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d requests, checked %0d results incl. full heap, ties and stalls",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
